[sv/mte_pkg.sv]
// Shared types and constants for the multiset table engine.
package mte_pkg;

  localparam int CAPACITY = 16;
  localparam int ELEM_W   = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  // Raw kind codes as they arrive on the input stream.
  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_REMOVE,
    OP_QUERY
  } op_t;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_FULL   = 2'd1,
    STATUS_EMPTY  = 2'd2,
    STATUS_ABSENT = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_WALK
  } state_t;

  typedef struct packed {
    op_t               op;
    logic [ELEM_W-1:0] element;
  } cmd_t;

  typedef struct packed {
    status_t    status;
    logic [4:0] copies;
    logic [4:0] occupancy;
    logic       is_empty;
  } result_t;

endpackage

[sv/mte_front.sv]
// Front end: accepts request beats, decodes the kind and queues commands.
module mte_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_kind,
  input  logic [31:0]           in_element,
  output logic                  cmd_valid,
  input  logic                  cmd_ready,
  output mte_pkg::cmd_t         cmd
);
  import mte_pkg::*;

  cmd_t              q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;
  cmd_t              decoded;

  // Unused kind code three is treated as a query.
  always_comb begin
    decoded.element = in_element[ELEM_W-1:0];
    case (in_kind)
      KIND_ADD:    decoded.op = OP_ADD;
      KIND_REMOVE: decoded.op = OP_REMOVE;
      default:     decoded.op = OP_QUERY;
    endcase
  end

  assign in_ready  = (count != QCNT_W'(QDEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = q[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= decoded;
    end
  end

endmodule

[sv/mte_back.sv]
// Back end: holds the table, walks it once per command and registers the result.
module mte_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  mte_pkg::cmd_t     cmd,
  output logic              res_valid,
  input  logic              res_ready,
  output mte_pkg::result_t  res
);
  import mte_pkg::*;

  state_t            state;
  state_t            state_next;
  logic [ELEM_W-1:0] entries [CAPACITY];
  logic [CNT_W-1:0]  fill;
  logic [CNT_W-1:0]  rd_idx;
  logic [CNT_W-1:0]  wr_idx;
  logic [CNT_W-1:0]  cnt;
  op_t               op;
  logic [ELEM_W-1:0] value;
  logic              add_full;
  logic              take;
  logic              stepping;
  logic              finish;
  logic              match;
  status_t           fin_status;
  logic [CNT_W-1:0]  fin_copies;
  logic [CNT_W-1:0]  fin_fill;

  assign match = (entries[rd_idx[IDX_W-1:0]] == value);

  always_comb begin
    state_next = state;
    cmd_ready  = (state == ST_IDLE);
    take       = 1'b0;
    stepping   = 1'b0;
    finish     = 1'b0;
    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          take       = 1'b1;
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (rd_idx != fill) begin
          stepping = 1'b1;
        end else if (!res_valid || res_ready) begin
          finish     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    fin_status = STATUS_OK;
    fin_copies = cnt;
    fin_fill   = fill;
    case (op)
      OP_ADD: begin
        if (add_full) begin
          fin_status = STATUS_FULL;
        end
      end
      OP_REMOVE: begin
        fin_copies = '0;
        if (fill == '0) begin
          fin_status = STATUS_EMPTY;
        end else if (cnt == '0) begin
          fin_status = STATUS_ABSENT;
        end else begin
          fin_fill = wr_idx;
        end
      end
      default: fin_status = STATUS_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (take && cmd.op == OP_ADD && fill != CNT_W'(CAPACITY)) begin
        fill <= fill + 1'b1;
      end else if (finish) begin
        fill <= fin_fill;
      end
      if (finish) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Compaction is done in place: the write index never passes the read index.
  always_ff @(posedge clk) begin
    if (take) begin
      op       <= cmd.op;
      value    <= cmd.element;
      rd_idx   <= '0;
      wr_idx   <= '0;
      cnt      <= '0;
      add_full <= (cmd.op == OP_ADD) && (fill == CNT_W'(CAPACITY));
      if (cmd.op == OP_ADD && fill != CNT_W'(CAPACITY)) begin
        entries[fill[IDX_W-1:0]] <= cmd.element;
      end
    end else if (stepping) begin
      rd_idx <= rd_idx + 1'b1;
      if (match) begin
        cnt <= cnt + 1'b1;
      end
      if (op == OP_REMOVE && !match) begin
        entries[wr_idx[IDX_W-1:0]] <= entries[rd_idx[IDX_W-1:0]];
        wr_idx <= wr_idx + 1'b1;
      end
    end
    if (finish) begin
      res.status    <= fin_status;
      res.copies    <= 5'(fin_copies);
      res.occupancy <= 5'(fin_fill);
      res.is_empty  <= (fin_fill == '0);
    end
  end

endmodule

[sv/multiset_table_engine.sv]
// Top level of the multiset table engine: request queue, table sequencer and port packing.
// The engine keeps up to CAPACITY values in insertion order and answers every request beat
// with exactly one result beat. A request is handled in steps: the command is taken from the
// queue, the table sequencer compares each held entry in turn (after an add, including the
// new one) and, for a remove, moves survivors down, and then the result register is loaded,
// which waits while an earlier result has not been taken. Add, remove and query all walk the
// whole occupied table: add and query results report the copy count, and a remove compacts.
// A two-beat queue in front of the sequencer and the result register behind it let requests
// arrive and results drain while a walk is in progress.
module multiset_table_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // element [31:0]
  input  logic [1:0]  s_tuser,   // kind [1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // copies [4:0], occupancy [9:5], is_empty [10], zero [15:11]
  output logic [1:0]  m_tuser    // status [1:0]
);
  import mte_pkg::*;

  logic    cmd_valid;
  logic    cmd_ready;
  cmd_t    cmd;
  result_t res;

  mte_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_kind    (s_tuser),
    .in_element (s_tdata),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd)
  );

  mte_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res       (res)
  );

  assign m_tuser = res.status;
  assign m_tdata = {5'd0, res.is_empty, res.occupancy, res.copies};

  // A refused add can only happen with the table full.
  a_full_occupancy: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == STATUS_FULL) |-> (m_tdata[9:5] == 5'(CAPACITY)))
    else $error("full status with occupancy below capacity");

  // A failed remove reports no copies.
  a_remove_copies: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == STATUS_EMPTY || m_tuser == STATUS_ABSENT)) |-> (m_tdata[4:0] == 5'd0))
    else $error("remove error reported nonzero copies");

  // The empty flag agrees with the occupancy.
  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[10] == (m_tdata[9:5] == 5'd0)))
    else $error("empty flag disagrees with occupancy");

  // Copies of one value never exceed the occupancy.
  a_copies_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[4:0] <= m_tdata[9:5]))
    else $error("copy count exceeds occupancy");

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for the multiset table engine: stream driver, predictor and monitor.
module tb_top;
  import mte_pkg::*;

  // Code 3 is not a named operation; the engine treats it as a count query.
  localparam logic [1:0] KIND_SPARE = 2'd3;

  typedef struct {
    logic [1:0]        kind;
    logic [ELEM_W-1:0] elem;
    bit                drain;  // hold this beat back until every answer is in
  } req_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [1:0]  m_tuser;

  multiset_table_engine dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #2 clk = ~clk;

  // Shadow copy of the table, updated as each request beat is accepted.
  logic [ELEM_W-1:0] shadow_vals [CAPACITY];
  int unsigned       shadow_fill = 0;

  req_t        pending_reqs[$];
  result_t     expected_results[$];
  int unsigned n_sent = 0;
  int unsigned n_checked = 0;
  int unsigned n_fail = 0;
  int unsigned tx_hold = 0;
  int unsigned rx_hold = 0;
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;

  function automatic int unsigned draw_gap(bit calm);
    return calm ? 0 : $urandom_range(0, 18);
  endfunction

  function automatic int unsigned shadow_copies(logic [ELEM_W-1:0] v);
    int unsigned n;
    n = 0;
    for (int i = 0; i < shadow_fill; i++)
      if (shadow_vals[i] == v) n++;
    return n;
  endfunction

  function automatic result_t apply_request(logic [1:0] kind, logic [ELEM_W-1:0] v);
    result_t     r;
    int unsigned n;
    int unsigned w;
    r.status = STATUS_OK;
    n = 0;
    if (kind == KIND_ADD) begin
      if (shadow_fill >= CAPACITY) begin
        r.status = STATUS_FULL;
      end else begin
        shadow_vals[shadow_fill] = v;
        shadow_fill++;
      end
      n = shadow_copies(v);
    end else if (kind == KIND_REMOVE) begin
      if (shadow_fill == 0) begin
        r.status = STATUS_EMPTY;
      end else if (shadow_copies(v) == 0) begin
        r.status = STATUS_ABSENT;
      end else begin
        // Survivors slide down and keep their order.
        w = 0;
        for (int i = 0; i < shadow_fill; i++) begin
          if (shadow_vals[i] != v) begin
            shadow_vals[w] = shadow_vals[i];
            w++;
          end
        end
        shadow_fill = w;
      end
    end else begin
      n = shadow_copies(v);
    end
    r.copies    = n[4:0];
    r.occupancy = shadow_fill[4:0];
    r.is_empty  = (shadow_fill == 0);
    return r;
  endfunction

  // Driver: predicts on every accepted beat, then presents the next one after its gap.
  always @(posedge clk) begin
    int unsigned sent_now;
    req_t        nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
      tx_hold  <= 0;
    end else begin
      sent_now = n_sent;
      if (s_tvalid && s_tready) begin
        expected_results.push_back(apply_request(s_tuser, s_tdata));
        sent_now = n_sent + 1;
        n_sent <= sent_now;
      end
      if (!s_tvalid || s_tready) begin
        if (tx_hold != 0) begin
          s_tvalid <= 1'b0;
          tx_hold  <= tx_hold - 1;
        end else if (pending_reqs.size() != 0 &&
                     (!pending_reqs[0].drain || sent_now == n_checked)) begin
          nxt = pending_reqs.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= nxt.kind;
          s_tdata  <= nxt.elem;
          if ($urandom_range(0, 24) == 0) tx_calm = !tx_calm;
          tx_hold <= draw_gap(tx_calm);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result beat against the oldest prediction and stalls at random.
  always @(posedge clk) begin
    result_t     want;
    int unsigned stall;
    if (rst) begin
      m_tready <= 1'b0;
      rx_hold  <= 0;
    end else if (m_tvalid && m_tready) begin
      if (n_sent == n_checked) begin
        $error("result beat with no request outstanding");
        n_fail++;
      end else begin
        want = expected_results.pop_front();
        n_checked <= n_checked + 1;
        if (m_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_tuser);
          n_fail++;
        end
        if (m_tdata[4:0] !== want.copies) begin
          $error("copies: expected %0d, got %0d", want.copies, m_tdata[4:0]);
          n_fail++;
        end
        if (m_tdata[9:5] !== want.occupancy) begin
          $error("occupancy: expected %0d, got %0d", want.occupancy, m_tdata[9:5]);
          n_fail++;
        end
        if (m_tdata[10] !== want.is_empty) begin
          $error("is_empty: expected %0d, got %0d", want.is_empty, m_tdata[10]);
          n_fail++;
        end
      end
      if ($urandom_range(0, 24) == 0) rx_calm = !rx_calm;
      stall = draw_gap(rx_calm);
      if (stall == 0) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b0;
        rx_hold  <= stall;
      end
    end else if (rx_hold != 0) begin
      if (rx_hold == 1) m_tready <= 1'b1;
      rx_hold <= rx_hold - 1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic queue_req(logic [1:0] kind, logic [ELEM_W-1:0] v, bit drain);
    req_t q;
    q.kind  = kind;
    q.elem  = v;
    q.drain = drain;
    pending_reqs.push_back(q);
  endtask

  initial begin
    logic [ELEM_W-1:0] pool [6];
    int unsigned       add_pct;
    int unsigned       pick;
    logic [1:0]        kind;
    logic [ELEM_W-1:0] v;

    // Directed part: empty table, extreme values, duplicates, filling up and compaction.
    queue_req(KIND_QUERY, '0, 1'b0);
    queue_req(KIND_REMOVE, 32'h0000_0005, 1'b0);
    queue_req(KIND_ADD, '0, 1'b0);
    queue_req(KIND_ADD, '1, 1'b0);
    queue_req(KIND_ADD, '1, 1'b0);
    queue_req(KIND_QUERY, '1, 1'b0);
    queue_req(KIND_REMOVE, 32'h0001_2345, 1'b0);
    queue_req(KIND_SPARE, '1, 1'b0);
    queue_req(KIND_REMOVE, '1, 1'b0);
    for (int i = 0; i < 15; i++)
      queue_req(KIND_ADD, (i % 2 == 0) ? 32'hA5A5_A5A5 : 32'h5A5A_5A5A, 1'b0);
    // The table is full here; this beat waits until the pipeline has drained.
    queue_req(KIND_ADD, 32'h5A5A_5A5A, 1'b1);
    queue_req(KIND_REMOVE, 32'hA5A5_A5A5, 1'b0);
    queue_req(KIND_REMOVE, '0, 1'b0);

    // Random part: rounds lean toward adds or removes so the table swings
    // between empty and full, over a small pool of values so removes hit.
    for (int i = 0; i < 6; i++) pool[i] = $urandom();
    for (int r = 0; r < 14; r++) begin
      pick = $urandom_range(0, 2);
      add_pct = (pick == 0) ? 25 : (pick == 1) ? 50 : 85;
      for (int i = 0; i < 30; i++) begin
        if ($urandom_range(0, 99) < add_pct) begin
          kind = KIND_ADD;
        end else begin
          pick = $urandom_range(0, 9);
          kind = (pick < 6) ? KIND_REMOVE : (pick < 9) ? KIND_QUERY : KIND_SPARE;
        end
        v = ($urandom_range(0, 6) == 0) ? $urandom() : pool[$urandom_range(0, 5)];
        queue_req(kind, v, $urandom_range(0, 59) == 0);
      end
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || s_tvalid) @(negedge clk);
    while (n_checked != n_sent) @(negedge clk);
    repeat (40) @(negedge clk);
    if (n_fail == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule
